[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/bpc_pkg.sv]
`default_nettype none
package bpc_pkg;

  localparam int TQ_BITS = 28;   // temperature divider dividend width
  localparam int PQ_BITS = 32;   // pressure divider dividend width

  localparam logic [3:0] REG_AC1   = 4'd0;
  localparam logic [3:0] REG_AC2   = 4'd1;
  localparam logic [3:0] REG_AC3   = 4'd2;
  localparam logic [3:0] REG_AC4   = 4'd3;
  localparam logic [3:0] REG_AC5   = 4'd4;
  localparam logic [3:0] REG_AC6   = 4'd5;
  localparam logic [3:0] REG_B1_B2 = 4'd6;
  localparam logic [3:0] REG_MC_MD = 4'd7;

  localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;
  localparam logic signed [31:0] P_C1       = 32'sd3038;
  localparam logic signed [31:0] P_C2       = -32'sd7357;
  localparam logic signed [31:0] P_C3       = 32'sd3791;

  typedef struct packed {
    logic               err;
    logic [15:0]        up;
    logic signed [31:0] temp;
  } ctx_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic signed [31:0]   x1;
    logic                 neg;
    logic [31:0]          dvs;
    logic [31:0]          rem;
    logic [TQ_BITS-1:0]   q;
  } tdiv_t;

  typedef struct packed {
    ctx_t                 ctx;
    logic                 hi;
    logic [16:0]          dvs;
    logic [16:0]          rem;
    logic [PQ_BITS-1:0]   q;
  } pdiv_t;

  function automatic tdiv_t tdiv_step(input tdiv_t s);
    tdiv_t       r;
    logic [32:0] tr;
    logic        ge;
    r  = s;
    tr = {s.rem, s.q[TQ_BITS-1]};
    ge = (tr >= {1'b0, s.dvs});
    r.rem = ge ? 32'(tr - {1'b0, s.dvs}) : tr[31:0];
    r.q   = {s.q[TQ_BITS-2:0], ge};
    return r;
  endfunction

  function automatic pdiv_t pdiv_step(input pdiv_t s);
    pdiv_t       r;
    logic [17:0] tr;
    logic        ge;
    r  = s;
    tr = {s.rem, s.q[PQ_BITS-1]};
    ge = (tr >= {1'b0, s.dvs});
    r.rem = ge ? 17'(tr - {1'b0, s.dvs}) : tr[16:0];
    r.q   = {s.q[PQ_BITS-2:0], ge};
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/barometric_pressure_compensation_unit.sv]
// Pressure/temperature compensation pipeline. One word per cycle in, one per cycle out
// while the output is not stalled. It holds a bit-per-stage temperature divider (load plus
// 28 steps) and a bit-per-stage pressure divider (load plus 32 steps), with multiply and
// output stages around them. A stall on the output freezes the whole pipeline.
// Calibration writes take effect at once and should only be made while the pipeline is
// empty. A zero divisor gives zero results with divide_error set.
`default_nettype none
module barometric_pressure_compensation_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         in_raw_temperature,
  input  wire logic [15:0]         in_raw_pressure,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_temperature_tenths,
  output logic signed [31:0]       out_pressure_pa,
  output logic                     out_divide_error,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [3:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  localparam int TQ = bpc_pkg::TQ_BITS;
  localparam int PQ = bpc_pkg::PQ_BITS;

  logic signed [15:0] ac1_r, ac2_r, ac3_r;
  logic [15:0]        ac4_r, ac5_r, ac6_r;
  logic [31:0]        b1b2_r, mcmd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r  <= 16'sd408;
      ac2_r  <= -16'sd72;
      ac3_r  <= -16'sd14383;
      ac4_r  <= 16'd32741;
      ac5_r  <= 16'd32757;
      ac6_r  <= 16'd23153;
      b1b2_r <= 32'd405667844;
      mcmd_r <= 32'd3724086068;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_AC1:   ac1_r  <= $signed(cfg_data[15:0]);
        bpc_pkg::REG_AC2:   ac2_r  <= $signed(cfg_data[15:0]);
        bpc_pkg::REG_AC3:   ac3_r  <= $signed(cfg_data[15:0]);
        bpc_pkg::REG_AC4:   ac4_r  <= cfg_data[15:0];
        bpc_pkg::REG_AC5:   ac5_r  <= cfg_data[15:0];
        bpc_pkg::REG_AC6:   ac6_r  <= cfg_data[15:0];
        bpc_pkg::REG_B1_B2: b1b2_r <= cfg_data;
        bpc_pkg::REG_MC_MD: mcmd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] b1, b2, mc, md;
  assign b1 = $signed(b1b2_r[31:16]);
  assign b2 = $signed(b1b2_r[15:0]);
  assign mc = $signed(mcmd_r[31:16]);
  assign md = $signed(mcmd_r[15:0]);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: (UT - AC6) * AC5
  logic signed [17:0] d_a;
  logic signed [34:0] prod_a;
  logic               a_vld_r;
  logic signed [31:0] a_p_r;
  logic [15:0]        a_up_r;
  assign d_a    = $signed({2'b00, in_raw_temperature}) - $signed({2'b00, ac6_r});
  assign prod_a = d_a * $signed({1'b0, ac5_r});

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r  <= prod_a[31:0];
      a_up_r <= in_raw_pressure;
    end
  end

  // stage B: X1, denominator, divider load
  logic signed [31:0] x1_b, den_b;
  logic signed [16:0] mc17;
  logic [16:0]        mc_mag;
  bpc_pkg::tdiv_t     tload;
  assign x1_b   = a_p_r >>> 15;
  assign den_b  = x1_b + 32'(md);
  assign mc17   = {mc[15], mc};
  assign mc_mag = mc17[16] ? 17'(-mc17) : 17'(mc17);

  always_comb begin
    tload          = '0;
    tload.ctx.err  = (den_b == 32'sd0);
    tload.ctx.up   = a_up_r;
    tload.ctx.temp = '0;
    tload.x1       = x1_b;
    tload.neg      = mc[15] ^ den_b[31];
    tload.dvs      = den_b[31] ? 32'(-den_b) : 32'(den_b);
    tload.rem      = '0;
    tload.q        = {mc_mag, 11'b0};
  end

  logic [TQ:0]    tv_r;
  bpc_pkg::tdiv_t tdiv_r [0:TQ];

  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= '0;
    else if (en) tv_r <= {tv_r[TQ-1:0], a_vld_r};
  end
  always_ff @(posedge clk) begin
    if (en) tdiv_r[0] <= tload;
  end
  for (genvar i = 0; i < TQ; i++) begin : g_tdiv
    always_ff @(posedge clk) begin
      if (en) tdiv_r[i+1] <= bpc_pkg::tdiv_step(tdiv_r[i]);
    end
  end

  // stage C: B5, temperature, B6
  logic signed [31:0] x2_c, b5_c;
  logic               c_vld_r;
  bpc_pkg::ctx_t      c_ctx_r;
  bpc_pkg::ctx_t      c_ctx_nxt;
  logic signed [31:0] c_b6_r;
  assign x2_c = tdiv_r[TQ].neg ? -$signed({4'b0, tdiv_r[TQ].q}) : $signed({4'b0, tdiv_r[TQ].q});
  assign b5_c = tdiv_r[TQ].x1 + x2_c;

  always_comb begin
    c_ctx_nxt      = tdiv_r[TQ].ctx;
    c_ctx_nxt.temp = (b5_c + 32'sd8) >>> 4;
  end

  // stages D..L
  logic               d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r, k_vld_r, l_vld_r;
  bpc_pkg::ctx_t      d_ctx_r, e_ctx_r, f_ctx_r, g_ctx_r, h_ctx_r, k_ctx_r, l_ctx_r;
  logic signed [31:0] d_sq_r, d_m2_r, d_m3_r;
  logic signed [31:0] e_sq_r, e_x2a_r, e_x1c_r;
  logic signed [31:0] f_m1_r, f_m2_r, f_x2a_r, f_x1c_r;
  logic signed [31:0] g_b3_r, g_x3_r;
  logic [31:0]        h_b4p_r, h_diff_r;
  logic signed [31:0] k_p_r, k_tt_r, k_m_r;
  logic signed [31:0] l_p_r, l_m1_r, l_x2_r;

  logic signed [31:0] x3_g, v_g, sum_g;
  logic [31:0]        s_h, b7_i;
  logic [16:0]        b4_i;
  bpc_pkg::pdiv_t     pload;
  logic signed [31:0] p_k, t_k, pf_m;

  assign x3_g  = (f_m1_r >>> 11) + f_x2a_r;
  assign v_g   = (32'(ac1_r) * 32'sd4) + x3_g + 32'sd2;
  assign sum_g = (f_m2_r >>> 16) + f_x1c_r + 32'sd2;
  assign s_h   = 32'(g_x3_r + bpc_pkg::B4_OFFSET);
  assign b4_i  = h_b4p_r[31:15];
  assign b7_i  = h_diff_r * bpc_pkg::B7_SCALE;

  always_comb begin
    pload         = '0;
    pload.ctx     = h_ctx_r;
    pload.ctx.err = h_ctx_r.err || (b4_i == 17'd0);
    pload.hi      = b7_i[31];
    pload.dvs     = b4_i;
    pload.rem     = '0;
    pload.q       = b7_i[31] ? b7_i : {b7_i[30:0], 1'b0};
  end

  logic [PQ:0]    uv_r;
  bpc_pkg::pdiv_t pdiv_r [0:PQ];

  assign p_k  = pdiv_r[PQ].hi ? $signed({pdiv_r[PQ].q[30:0], 1'b0}) : $signed(pdiv_r[PQ].q);
  assign t_k  = p_k >>> 8;
  assign pf_m = l_p_r + (((l_m1_r >>> 16) + l_x2_r + bpc_pkg::P_C3) >>> 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      uv_r      <= '0;
      k_vld_r   <= 1'b0;
      l_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c_vld_r   <= tv_r[TQ];
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= f_vld_r;
      h_vld_r   <= g_vld_r;
      uv_r      <= {uv_r[PQ-1:0], h_vld_r};
      k_vld_r   <= uv_r[PQ];
      l_vld_r   <= k_vld_r;
      out_valid <= l_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctx_r <= c_ctx_nxt;
      c_b6_r  <= b5_c - bpc_pkg::B6_OFFSET;

      d_ctx_r <= c_ctx_r;
      d_sq_r  <= c_b6_r * c_b6_r;
      d_m2_r  <= c_b6_r * 32'(ac2_r);
      d_m3_r  <= c_b6_r * 32'(ac3_r);

      e_ctx_r <= d_ctx_r;
      e_sq_r  <= d_sq_r >>> 12;
      e_x2a_r <= d_m2_r >>> 11;
      e_x1c_r <= d_m3_r >>> 13;

      f_ctx_r <= e_ctx_r;
      f_m1_r  <= e_sq_r * 32'(b2);
      f_m2_r  <= e_sq_r * 32'(b1);
      f_x2a_r <= e_x2a_r;
      f_x1c_r <= e_x1c_r;

      g_ctx_r <= f_ctx_r;
      g_b3_r  <= (v_g + (v_g[31] ? 32'sd3 : 32'sd0)) >>> 2;
      g_x3_r  <= sum_g >>> 2;

      h_ctx_r  <= g_ctx_r;
      h_b4p_r  <= {16'b0, ac4_r} * s_h;
      h_diff_r <= 32'({16'b0, g_ctx_r.up}) - 32'(g_b3_r);

      pdiv_r[0] <= pload;

      k_ctx_r <= pdiv_r[PQ].ctx;
      k_p_r   <= p_k;
      k_tt_r  <= t_k * t_k;
      k_m_r   <= p_k * bpc_pkg::P_C2;

      l_ctx_r <= k_ctx_r;
      l_p_r   <= k_p_r;
      l_m1_r  <= k_tt_r * bpc_pkg::P_C1;
      l_x2_r  <= k_m_r >>> 16;

      out_divide_error       <= l_ctx_r.err;
      out_temperature_tenths <= l_ctx_r.err ? 32'sd0 : l_ctx_r.temp;
      out_pressure_pa        <= l_ctx_r.err ? 32'sd0 : pf_m;
    end
  end

  for (genvar j = 0; j < PQ; j++) begin : g_pdiv
    always_ff @(posedge clk) begin
      if (en) pdiv_r[j+1] <= bpc_pkg::pdiv_step(pdiv_r[j]);
    end
  end

`include "assert_macros.svh"

  `BPC_ASSERT_IMP(a_err_zero, out_valid && out_divide_error,
    out_temperature_tenths == 32'sd0 && out_pressure_pa == 32'sd0)
  `BPC_ASSERT_NXT(a_stall_freeze, out_valid && !out_ready,
    $stable(tv_r) && $stable(uv_r) && out_valid)

endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 72;
  localparam logic [3:0] REG_NONE = 4'd9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_raw_temperature = '0;
  logic [15:0] in_raw_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_temperature_tenths;
  logic signed [31:0] out_pressure_pa;
  logic out_divide_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  barometric_pressure_compensation_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] pres;
    logic               err;
  } reading_t;

  reading_t expected_readings[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  logic signed [31:0] ac1, ac2, ac3;
  logic [31:0] ac4, ac5, ac6, b1_b2, mc_md;

  task automatic load_defaults();
    ac1 = 408; ac2 = -72; ac3 = -14383;
    ac4 = 32741; ac5 = 32757; ac6 = 23153;
    b1_b2 = 32'd405667844; mc_md = 32'd3724086068;
  endtask

  function automatic logic signed [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] quot(logic signed [31:0] a, logic signed [31:0] b);
    if (a == 32'sh80000000 && b == -1) return a;
    return a / b;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut, logic [15:0] up);
    reading_t r;
    logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, t, p, den, b1, b2, mc, md;
    logic [31:0] b4, b7, pu;
    r = '{temp: 0, pres: 0, err: 1'b1};
    b1 = sx16(b1_b2[31:16]); b2 = sx16(b1_b2[15:0]);
    mc = sx16(mc_md[31:16]); md = sx16(mc_md[15:0]);
    x1 = ($signed({16'd0, ut}) - $signed(ac6)) * $signed(ac5);
    x1 = x1 >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = quot(mc * 2048, den);
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = quot(ac1 * 4 + x3 + 2, 4);
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * 32'(x3 + 32768)) >> 15;
    if (b4 == 0) return r;
    b7 = 32'($signed({16'd0, up}) - b3) * 32'd50000;
    if (b7 < 32'h80000000) pu = (b7 << 1) / b4;
    else pu = (b7 / b4) << 1;
    p = pu;
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-32'sd7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    r = '{temp: t, pres: p, err: 1'b0};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report("unexpected word", out_pressure_pa, 0);
        end else begin
          reading_t e;
          e = expected_readings.pop_front();
          if (out_temperature_tenths !== e.temp)
            report("temperature", out_temperature_tenths, e.temp);
          if (out_pressure_pa !== e.pres) report("pressure", out_pressure_pa, e.pres);
          if (out_divide_error !== e.err) report("divide_error", out_divide_error, e.err);
        end
      end
    end
  end

  task automatic send_reading(logic [15:0] ut, logic [15:0] up);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(compensate(ut, up));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bpc_pkg::REG_AC1: ac1 = sx16(val[15:0]);
      bpc_pkg::REG_AC2: ac2 = sx16(val[15:0]);
      bpc_pkg::REG_AC3: ac3 = sx16(val[15:0]);
      bpc_pkg::REG_AC4: ac4 = val[15:0];
      bpc_pkg::REG_AC5: ac5 = val[15:0];
      bpc_pkg::REG_AC6: ac6 = val[15:0];
      bpc_pkg::REG_B1_B2: b1_b2 = val;
      bpc_pkg::REG_MC_MD: mc_md = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_burst(int n);
    repeat (n) send_reading(16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_reading(16'd27898, 16'd23843);
    send_reading(16'h0000, 16'h0000);
    send_reading(16'hffff, 16'hffff);
    send_reading(16'h0000, 16'hffff);
    send_reading(16'hffff, 16'h0000);
    send_reading(16'h8000, 16'h8000);
    send_reading(16'h5555, 16'haaaa);
    send_reading(16'haaaa, 16'h5555);
    drain();
    // temperature divisor zero: ut == ac6, md == 0
    write_reg(bpc_pkg::REG_MC_MD, 32'hd4bd_0000);
    send_reading(16'd23153, 16'd30000);
    send_reading(16'd23154, 16'd30000);
    drain();
    // pressure divisor zero: ac4 == 0
    write_reg(bpc_pkg::REG_MC_MD, 32'd3724086068);
    write_reg(bpc_pkg::REG_AC4, 32'd0);
    send_reading(16'd27898, 16'd23843);
    drain();
    write_reg(REG_NONE, 32'hffff_ffff);
    write_reg(bpc_pkg::REG_AC4, 32'd32741);
    send_reading(16'd27898, 16'd23843);
    drain();
  endtask

  task automatic test_extreme_coefficients();
    logic [3:0] i;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 8; r++) begin
        i = r[3:0];
        case (k)
          0: write_reg(i, 32'hffff_ffff);
          1: write_reg(i, 32'h8000_8000);
          default: write_reg(i, 32'h7fff_7fff);
        endcase
      end
      random_burst(40);
      drain();
    end
  endtask

  task automatic test_random_coefficients();
    repeat (6) begin
      for (int r = 0; r < 8; r++) write_reg(r[3:0], $urandom);
      random_burst(60);
      drain();
    end
    load_defaults();
    for (int r = 0; r < 8; r++) begin
      case (r[3:0])
        bpc_pkg::REG_AC1: write_reg(bpc_pkg::REG_AC1, ac1);
        bpc_pkg::REG_AC2: write_reg(bpc_pkg::REG_AC2, ac2);
        bpc_pkg::REG_AC3: write_reg(bpc_pkg::REG_AC3, ac3);
        bpc_pkg::REG_AC4: write_reg(bpc_pkg::REG_AC4, ac4);
        bpc_pkg::REG_AC5: write_reg(bpc_pkg::REG_AC5, ac5);
        bpc_pkg::REG_AC6: write_reg(bpc_pkg::REG_AC6, ac6);
        bpc_pkg::REG_B1_B2: write_reg(bpc_pkg::REG_B1_B2, b1_b2);
        default: write_reg(bpc_pkg::REG_MC_MD, mc_md);
      endcase
    end
  endtask

  task automatic test_flow_control();
    int pct[4] = '{0, 67, 0, 67};
    int rpct[4] = '{0, 0, 67, 67};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct[ph];
      recv_stall_pct = (ph == 3) ? 7 : rpct[ph];
      if (ph == 3) send_idle_pct = 7;
      random_burst(250);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    random_burst(120);
    drain();
    recv_stall_pct = 30;
    random_burst(200);
    recv_stall_pct = 0;
  endtask

  initial begin
    load_defaults();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extreme_coefficients();
    test_random_coefficients();
    test_flow_control();
    drain();
    if (error_count == 0) begin
      $display("PASS barometric_pressure_compensation_unit");
    end else begin
      $display("FAIL barometric_pressure_compensation_unit");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL barometric_pressure_compensation_unit");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/barometric_pressure_compensation_unit.sv
bench/testbench.sv
